### hw/rtl/bilinear_image_downscaler_unit_defines.svh
// Assertion macros shared by the downscaler RTL modules.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef BILINEAR_IMAGE_DOWNSCALER_UNIT_DEFINES_SVH
`define BILINEAR_IMAGE_DOWNSCALER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BIDS_ASSERT_IMP(name, cond, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define BIDS_ASSERT_NXT(name, cond, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) else $error(msg);

`endif

### hw/rtl/bids_pkg.sv
// Types, constants and the blend function of the bilinear downscaler.
// No dependencies; used by the controller, the datapath and the top level.
`default_nettype none
package bids_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int FRAC_W     = 16;
  localparam int POS_W      = 28;
  localparam int DIM_W      = 12;
  localparam int PLANES_W   = 3;
  localparam int STEP_W     = 19;
  localparam int COORD_W    = 9;
  localparam int PLANE_W    = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int ROW_LIMIT  = 2048;
  localparam int PLANE_MAX  = 4;
  localparam int OUT_DATA_W = 40;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_COUNT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_H_STEP      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_V_STEP      = 3'd4;

  // Register reset values.
  localparam logic [DIM_W-1:0]    RST_SRC_WIDTH   = 12'd1920;
  localparam logic [DIM_W-1:0]    RST_SRC_HEIGHT  = 12'd1080;
  localparam logic [PLANES_W-1:0] RST_PLANE_COUNT = 3'd3;
  localparam logic [STEP_W-1:0]   RST_H_STEP      = 19'd303044;
  localparam logic [STEP_W-1:0]   RST_V_STEP      = 19'd170394;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic calc;
    logic rd;
    logic emit_row;
    logic emit_last;
    logic wr;
    logic upd;
    logic slot;
  } bids_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic s0_act;
    logic s1_act;
    logic row_act;
    logic last_act;
    logic out_free;
  } bids_sts_t;

  // Rounded blend ((2^16 - f) * a + f * b) / 2^16, written as a + f * (b - a) / 2^16.
  function automatic logic [SAMPLE_W-1:0] blend(input logic [SAMPLE_W-1:0] a,
                                                input logic [SAMPLE_W-1:0] b,
                                                input logic [FRAC_W-1:0] f);
    logic signed [SAMPLE_W:0]       diff;
    logic signed [FRAC_W:0]         fs;
    logic signed [SAMPLE_W+FRAC_W+1:0] prod;
    logic signed [SAMPLE_W+FRAC_W+2:0] acc;
    logic [SAMPLE_W+2:0]            sum;
    diff = signed'({1'b0, b}) - signed'({1'b0, a});
    fs   = signed'({1'b0, f});
    prod = diff * fs;
    acc  = {prod[SAMPLE_W+FRAC_W+1], prod} + (35'sd1 <<< (FRAC_W - 1));
    sum  = {3'b000, a} + acc[SAMPLE_W+FRAC_W+2:FRAC_W];
    return sum[SAMPLE_W-1:0];
  endfunction

endpackage
`default_nettype wire

### hw/rtl/bilinear_image_downscaler_unit.sv
// Top level of the streaming separable bilinear downscaler.
// Depends on bids_pkg, bids_ctrl, bids_datapath and bids_ram.
//
// Source samples enter on the in_ stream one per transaction, in plane, row,
// column order; in_tuser marks the first pixel of a frame and restarts all
// position counters. Each pixel causes zero to four destination samples on
// the out_ stream; out_tlast marks the last one caused by that pixel.
// Registers are written on the cfg_ channel (index 0 source width, 1 source
// height, 2 plane count, 3 horizontal step, 4 vertical step); the user must
// write them only while idle, as the block itself does not enforce it.
// One pixel is handled at a time by a controller stepping through the blends
// and a row store with one write and one read port; a pixel uses no column
// slot, one or both, each result being registered the cycle it is made.
// When the receiver stalls, the result waits in the output register and the
// controller holds until it is taken. After reset the registers hold their
// default values and the counters are zero; the row store needs no clearing.
`default_nettype none
module bilinear_image_downscaler_unit #(
  parameter int DEST_WIDTH    = 416,
  parameter int DEST_HEIGHT   = 416,
  parameter int MAX_SRC_WIDTH = 2048
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [bids_pkg::SAMPLE_W-1:0]      in_tdata,   // [15:0] pixel_value
  input  wire logic                               in_tuser,   // [0] frame_start
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // [15:0] out_value, [24:16] out_x, [33:25] out_y, [35:34] out_plane, rest zero
  output logic [bids_pkg::OUT_DATA_W-1:0]         out_tdata,
  output logic                                    out_tlast,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [bids_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [bids_pkg::STEP_W-1:0]        cfg_data
);
  import bids_pkg::*;

  bids_cmd_t cmd;
  bids_sts_t sts;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  // Sequencer.
  bids_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Arithmetic, counters and row store.
  bids_datapath #(
    .DEST_WIDTH   (DEST_WIDTH),
    .DEST_HEIGHT  (DEST_HEIGHT),
    .MAX_SRC_WIDTH(MAX_SRC_WIDTH)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_pixel      (in_tdata),
    .in_frame_start(in_tuser),
    .cfg_wr        (cfg_valid & cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_data      (out_tdata),
    .out_last      (out_tlast)
  );

endmodule
`default_nettype wire

### hw/rtl/bids_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none
module bids_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 416
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port; data holds between reads.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule
`default_nettype wire

### hw/rtl/bids_ctrl.sv
// Controller state machine of the downscaler: sequences one input pixel.
// Depends on bids_pkg and the assertion macro header.
`default_nettype none
`include "bilinear_image_downscaler_unit_defines.svh"
module bids_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire bids_pkg::bids_sts_t sts,
  output bids_pkg::bids_cmd_t      cmd
);
  import bids_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CALC  = 3'd1;
  localparam logic [2:0] ST_SEL   = 3'd2;
  localparam logic [2:0] ST_READ  = 3'd3;
  localparam logic [2:0] ST_ROW   = 3'd4;
  localparam logic [2:0] ST_LAST  = 3'd5;
  localparam logic [2:0] ST_WRITE = 3'd6;
  localparam logic [2:0] ST_UPD   = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       slot_r, slot_nxt;

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    slot_nxt  = slot_r;
    cmd       = '0;
    cmd.slot  = slot_r;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CALC;
        end
      end
      ST_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = ST_SEL;
      end
      ST_SEL: begin
        if (sts.s0_act) begin
          slot_nxt  = 1'b0;
          state_nxt = ST_READ;
        end else if (sts.s1_act) begin
          slot_nxt  = 1'b1;
          state_nxt = ST_READ;
        end else begin
          state_nxt = ST_UPD;
        end
      end
      ST_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_ROW;
      end
      ST_ROW: begin
        if (!sts.row_act) begin
          state_nxt = ST_LAST;
        end else if (sts.out_free) begin
          cmd.emit_row = 1'b1;
          state_nxt    = ST_LAST;
        end
      end
      ST_LAST: begin
        if (!sts.last_act) begin
          state_nxt = ST_WRITE;
        end else if (sts.out_free) begin
          cmd.emit_last = 1'b1;
          state_nxt     = ST_WRITE;
        end
      end
      ST_WRITE: begin
        cmd.wr = 1'b1;
        if (!slot_r && sts.s1_act) begin
          slot_nxt  = 1'b1;
          state_nxt = ST_READ;
        end else begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      slot_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      slot_r  <= slot_nxt;
    end
  end

  // A result is only issued when the output register can take it.
  `BIDS_ASSERT_IMP(a_emit_free, cmd.emit_row || cmd.emit_last, sts.out_free, "emit while output busy")
  // An accepted pixel always moves on to the calculation step.
  `BIDS_ASSERT_NXT(a_load_calc, cmd.load, state_r == ST_CALC, "load not followed by calc")

endmodule
`default_nettype wire

### hw/rtl/bids_datapath.sv
// Datapath of the downscaler: registers, position counters, blends, row store.
// Depends on bids_pkg, bids_ram and the assertion macro header.
`default_nettype none
`include "bilinear_image_downscaler_unit_defines.svh"
module bids_datapath #(
  parameter int DEST_WIDTH    = 416,
  parameter int DEST_HEIGHT   = 416,
  parameter int MAX_SRC_WIDTH = 2048
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire bids_pkg::bids_cmd_t                   cmd,
  output bids_pkg::bids_sts_t                        sts,
  input  wire logic [bids_pkg::SAMPLE_W-1:0]         in_pixel,
  input  wire logic                                  in_frame_start,
  input  wire logic                                  cfg_wr,
  input  wire logic [bids_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [bids_pkg::STEP_W-1:0]           cfg_data,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic [bids_pkg::OUT_DATA_W-1:0]            out_data,
  output logic                                       out_last
);
  import bids_pkg::*;

  localparam int CW  = $clog2(DEST_WIDTH);
  localparam int RW  = $clog2(DEST_HEIGHT);
  localparam int SCW = $clog2(MAX_SRC_WIDTH);
  localparam int RCW = $clog2(ROW_LIMIT);
  localparam logic [CW-1:0] LAST_COL = CW'(DEST_WIDTH - 1);
  localparam logic [RW-1:0] LAST_VROW = RW'(DEST_HEIGHT - 1);
  localparam logic [COORD_W-1:0] LAST_Y = COORD_W'(DEST_HEIGHT - 1);
  localparam logic [DIM_W:0] MAX_W = (DIM_W+1)'(MAX_SRC_WIDTH);
  localparam logic [DIM_W:0] MAX_H = (DIM_W+1)'(ROW_LIMIT);
  localparam logic [RW-1:0] LH = RW'(DEST_HEIGHT - 1);

  // Configuration registers.
  logic [DIM_W-1:0]    src_width_r, src_height_r;
  logic [PLANES_W-1:0] plane_count_r;
  logic [STEP_W-1:0]   h_step_r, v_step_r;

  // Position state.
  logic [SAMPLE_W-1:0] px_r, prev_r;
  logic [SCW-1:0]      src_col_r;
  logic [RCW-1:0]      src_row_r;
  logic [PLANE_W-1:0]  plane_r;
  logic [CW-1:0]       next_hcol_r;
  logic [POS_W-1:0]    h_pos_r;
  logic [RW-1:0]       next_vrow_r;
  logic [POS_W-1:0]    v_pos_r;

  // Per-pixel decisions.
  logic                s0_r, s1_r, row_act_r, last_act_r, row_end_r;
  logic [FRAC_W-1:0]   vdy_r, ldy_r;
  logic [SAMPLE_W-1:0] hv0_r;

  // Output register.
  logic                out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                out_last_r;

  logic [DIM_W:0]      ew, eh;
  logic [2:0]          ep;
  logic                row_end_c, s0_c, row_act_c, last_act_c;
  logic [POS_W:0]      lpos_full;
  logic [POS_W-1:0]    lpos;
  logic [CW-1:0]       col;
  logic [SAMPLE_W-1:0] hv, stored, res;
  logic [SAMPLE_W-1:0] ram_rdata;
  logic [3:0]          mask;
  logic [1:0]          ridx;
  logic                is_last;
  logic [COORD_W-1:0]  res_y;
  logic                emit;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r   <= RST_SRC_WIDTH;
      src_height_r  <= RST_SRC_HEIGHT;
      plane_count_r <= RST_PLANE_COUNT;
      h_step_r      <= RST_H_STEP;
      v_step_r      <= RST_V_STEP;
    end else if (cfg_wr) begin
      case (cfg_index)
        REG_SRC_WIDTH:   src_width_r   <= cfg_data[DIM_W-1:0];
        REG_SRC_HEIGHT:  src_height_r  <= cfg_data[DIM_W-1:0];
        REG_PLANE_COUNT: plane_count_r <= cfg_data[PLANES_W-1:0];
        REG_H_STEP:      h_step_r      <= cfg_data;
        REG_V_STEP:      v_step_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamped dimensions and the decisions for the current pixel.
  always_comb begin
    ew = (src_width_r == '0) ? (DIM_W+1)'(1) :
         (({1'b0, src_width_r} > MAX_W) ? MAX_W : {1'b0, src_width_r});
    eh = (src_height_r == '0) ? (DIM_W+1)'(1) :
         (({1'b0, src_height_r} > MAX_H) ? MAX_H : {1'b0, src_height_r});
    ep = (plane_count_r == '0) ? 3'd1 :
         ((plane_count_r > 3'(PLANE_MAX)) ? 3'(PLANE_MAX) : plane_count_r);
    row_end_c  = ((DIM_W+1)'(src_col_r) + (DIM_W+1)'(1)) >= ew;
    s0_c       = (next_hcol_r < LAST_COL) &&
                 ((DIM_W+1)'(h_pos_r[POS_W-1:FRAC_W]) < (DIM_W+1)'(src_col_r));
    row_act_c  = (next_vrow_r < LAST_VROW) &&
                 ((DIM_W+1)'(v_pos_r[POS_W-1:FRAC_W]) < (DIM_W+1)'(src_row_r));
    lpos_full  = (POS_W+1)'(LH) * (POS_W+1)'(v_step_r);
    lpos       = lpos_full[POS_W-1:0];
    last_act_c = lpos[POS_W-1:FRAC_W] == (POS_W-FRAC_W)'(src_row_r);
  end

  // Pixel capture, per-pixel decisions and position counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r      <= '0;
      src_col_r   <= '0;
      src_row_r   <= '0;
      plane_r     <= '0;
      next_hcol_r <= '0;
      h_pos_r     <= '0;
      next_vrow_r <= '0;
      v_pos_r     <= '0;
      s0_r        <= 1'b0;
      s1_r        <= 1'b0;
      row_act_r   <= 1'b0;
      last_act_r  <= 1'b0;
      row_end_r   <= 1'b0;
    end else begin
      if (cmd.load && in_frame_start) begin
        src_col_r   <= '0;
        src_row_r   <= '0;
        plane_r     <= '0;
        next_hcol_r <= '0;
        h_pos_r     <= '0;
        next_vrow_r <= '0;
        v_pos_r     <= '0;
      end
      if (cmd.calc) begin
        s0_r       <= s0_c;
        s1_r       <= row_end_c;
        row_end_r  <= row_end_c;
        row_act_r  <= row_act_c;
        last_act_r <= last_act_c;
      end
      if (cmd.upd) begin
        prev_r <= px_r;
        if (row_end_r) begin
          src_col_r   <= '0;
          next_hcol_r <= '0;
          h_pos_r     <= '0;
          if ((DIM_W+1)'(src_row_r) + (DIM_W+1)'(1) >= eh) begin
            src_row_r   <= '0;
            next_vrow_r <= '0;
            v_pos_r     <= '0;
            plane_r     <= (3'(plane_r) + 3'd1 >= ep) ? '0 : plane_r + 1'b1;
          end else begin
            src_row_r <= src_row_r + 1'b1;
            if (row_act_r) begin
              next_vrow_r <= next_vrow_r + 1'b1;
              v_pos_r     <= v_pos_r + POS_W'(v_step_r);
            end
          end
        end else begin
          src_col_r <= src_col_r + 1'b1;
          if (s0_r) begin
            next_hcol_r <= next_hcol_r + 1'b1;
            h_pos_r     <= h_pos_r + POS_W'(h_step_r);
          end
        end
      end
    end
  end

  // Payload registers of the current pixel.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      px_r <= in_pixel;
    end
    if (cmd.calc) begin
      hv0_r <= blend(prev_r, px_r, h_pos_r[FRAC_W-1:0]);
      vdy_r <= v_pos_r[FRAC_W-1:0];
      ldy_r <= lpos[FRAC_W-1:0];
    end
  end

  // Row store of the previous resampled row.
  assign col = cmd.slot ? LAST_COL : next_hcol_r;
  assign hv  = cmd.slot ? px_r : hv0_r;

  bids_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(DEST_WIDTH)
  ) u_row_store (
    .clk  (clk),
    .we   (cmd.wr),
    .waddr(col),
    .wdata(hv),
    .re   (cmd.rd),
    .raddr(col),
    .rdata(ram_rdata)
  );

  assign stored = ram_rdata;

  // Result value and its end-of-run flag.
  always_comb begin
    mask = {s1_r & last_act_r, s1_r & row_act_r, s0_r & last_act_r, s0_r & row_act_r};
    ridx = {cmd.slot, cmd.emit_last};
    case (ridx)
      2'd0:    is_last = !(mask[1] | mask[2] | mask[3]);
      2'd1:    is_last = !(mask[2] | mask[3]);
      2'd2:    is_last = !mask[3];
      default: is_last = 1'b1;
    endcase
    res   = cmd.emit_last ? blend(hv, '0, ldy_r) : blend(stored, hv, vdy_r);
    res_y = cmd.emit_last ? LAST_Y : COORD_W'(next_vrow_r);
    emit  = cmd.emit_row | cmd.emit_last;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= OUT_DATA_W'({plane_r, res_y, COORD_W'(col), res});
      out_last_r <= is_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_last  = out_last_r;

  assign sts.s0_act   = s0_r;
  assign sts.s1_act   = s1_r;
  assign sts.row_act  = row_act_r;
  assign sts.last_act = last_act_r;
  assign sts.out_free = !out_valid_r || out_ready;

  // The horizontal counter never passes the last column.
  `BIDS_ASSERT_IMP(a_hcol_range, 1'b1, next_hcol_r <= LAST_COL, "column counter overflow")
  // The end of a source row restarts the horizontal position.
  `BIDS_ASSERT_NXT(a_row_wrap, cmd.upd && row_end_r, next_hcol_r == '0 && h_pos_r == '0, "row end did not restart columns")

endmodule
`default_nettype wire
